// File: design/bra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg: shared types and constants of the bitmap resource allocator
// Command codes, field widths, the sequencer states and the scan result.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int NUM_RESOURCES_DEF = 256;
  localparam int INDEX_SPAN        = 256;
  localparam int WORD_W            = 32;
  localparam int BIT_W             = 5;
  localparam int CMD_W             = 2;
  localparam int INDEX_W           = 8;
  localparam int COUNT_W           = 9;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY = 2'd0,
    CMD_BUSY  = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             any;
    logic [BIT_W-1:0] pos;
  } scan_res_t;

endpackage

// File: design/bra_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_req_if: request channel
// Carries one command and one resource index per item.
// ----------------------------------------------------------------------------
interface bra_req_if;
  logic                       valid;
  logic                       ready;
  logic [bra_pkg::CMD_W-1:0]   cmd;
  logic [bra_pkg::INDEX_W-1:0] rsrc_id;

  modport source (output valid, cmd, rsrc_id, input ready);
  modport sink   (input valid, cmd, rsrc_id, output ready);
endinterface

// File: design/bra_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_rsp_if: response channel
// Carries the busy bit, the bad index flag and the free search result.
// ----------------------------------------------------------------------------
interface bra_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       was_busy;
  logic                       bad_index;
  logic                       free_found;
  logic [bra_pkg::INDEX_W-1:0] free_index;

  modport source (output valid, was_busy, bad_index, free_found, free_index, input ready);
  modport sink   (input valid, was_busy, bad_index, free_found, free_index, output ready);
endinterface

// File: design/bra_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_cfg_if: configuration write channel
// Carries the resource count register's write data.
// ----------------------------------------------------------------------------
interface bra_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bra_pkg::COUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: design/bra_scan_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_scan_unit: free bit search over one bitmap word
// Masks the word to the bits at or below the limit, finds the highest free bit.
// ----------------------------------------------------------------------------
module bra_scan_unit (
  input  logic [bra_pkg::WORD_W-1:0] word,
  input  logic                       use_lim,
  input  logic [bra_pkg::BIT_W-1:0]  lim,
  output bra_pkg::scan_res_t         res
);
  import bra_pkg::*;

  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] free_bits;

  always_comb begin
    mask      = use_lim ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - lim)) : {WORD_W{1'b1}};
    free_bits = ~word & mask;
    res.any   = |free_bits;
    res.pos   = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (free_bits[i]) begin
        res.pos = BIT_W'(i);
      end
    end
  end

endmodule

// File: design/bra_bitmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_bitmap: usage bitmap storage
// Word array, one bit per resource, cleared to all free at reset.
// ----------------------------------------------------------------------------
module bra_bitmap #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [AW-1:0]              rd_addr,
  output logic [bra_pkg::WORD_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [bra_pkg::WORD_W-1:0] wr_data
);
  import bra_pkg::*;

  logic [WORD_W-1:0] words [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        words[i] <= '0;
      end
    end else if (wr_en) begin
      words[wr_addr] <= wr_data;
    end
  end

  assign rd_data = words[rd_addr];

endmodule

// File: design/bitmap_resource_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_resource_allocator: busy/free bitmap with highest-free search
// Query, mark busy or mark free one resource, then report the highest free
// resource below the configured count.
// ----------------------------------------------------------------------------
// The block keeps one busy bit per resource in 32-bit words and works on one
// item at a time. An accepted item first looks up and updates its word, then
// runs the highest-free search word by word, walking down from the word that
// holds the top counted resource and stopping at the first word with a free
// bit; the search covers at most the words in use (8 at 256 resources). The
// next item can be taken in the cycle after the result is taken. The shared
// word scan unit and the single bitmap read port are why the search goes word
// by word. An index at or above the effective count (resource_count limited
// to NUM_RESOURCES and to 256) leaves the bitmap alone and comes back with
// bad_index set and was_busy clear; a count of zero reports no free resource.
// Command 3 behaves as a query. Reset clears the bitmap at once and sets the
// count to 256; the count may be written whenever no item is in flight.
// ----------------------------------------------------------------------------
module bitmap_resource_allocator #(
  parameter int NUM_RESOURCES = bra_pkg::NUM_RESOURCES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bra_cfg_if.sink   cfg,
  bra_req_if.sink   req,
  bra_rsp_if.source rsp
);
  import bra_pkg::*;

  // Only indices below 256 can be named, so words past that span go unused.
  localparam int NUM_WORDS = (NUM_RESOURCES + WORD_W - 1) / WORD_W;
  localparam int DEPTH     = (NUM_WORDS < INDEX_SPAN / WORD_W) ? NUM_WORDS
                                                               : INDEX_SPAN / WORD_W;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EFF_MAX   = (NUM_RESOURCES < INDEX_SPAN) ? NUM_RESOURCES : INDEX_SPAN;

  state_t state, state_next;

  logic [COUNT_W-1:0] resource_count;
  logic [COUNT_W-1:0] count_eff;
  logic [COUNT_W-1:0] count_m1;

  // Item registers
  logic [CMD_W-1:0]   cmd_q;
  logic [INDEX_W-1:0] idx_q;
  logic [COUNT_W-1:0] count_q;
  logic [AW-1:0]      wptr,  wptr_next;
  logic               first, first_next;

  // Result registers
  logic               was_busy,   was_busy_next;
  logic               bad_index,  bad_index_next;
  logic               free_found, free_found_next;
  logic [INDEX_W-1:0] free_index, free_index_next;

  // Bitmap and scan unit hookup
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;
  logic [AW-1:0]     idx_word;
  logic [BIT_W-1:0]  idx_bit;
  logic              idx_bad;
  scan_res_t         scan;

  assign count_eff = (resource_count > COUNT_W'(EFF_MAX)) ? COUNT_W'(EFF_MAX) : resource_count;
  assign count_m1  = count_eff - COUNT_W'(1);

  assign idx_word = AW'(idx_q[INDEX_W-1:BIT_W]);
  assign idx_bit  = idx_q[BIT_W-1:0];
  assign idx_bad  = {1'b0, idx_q} >= count_q;

  // One read port: the item's own word while updating, the scan word otherwise.
  assign rd_addr = (state == ST_UPDATE) ? idx_word : wptr;

  bra_bitmap #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (idx_word),
    .wr_data (wr_data)
  );

  // The limit only applies to the top word, which is the first one scanned.
  bra_scan_unit u_scan (
    .word    (rd_data),
    .use_lim (first),
    .lim     (count_q[BIT_W-1:0] - BIT_W'(1)),
    .res     (scan)
  );

  // Configuration register; always ready.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      resource_count <= COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      resource_count <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the item and set up the scan start on accept.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      cmd_q   <= req.cmd;
      idx_q   <= req.rsrc_id;
      count_q <= count_eff;
    end
    wptr       <= wptr_next;
    first      <= first_next;
    was_busy   <= was_busy_next;
    bad_index  <= bad_index_next;
    free_found <= free_found_next;
    free_index <= free_index_next;
  end

  always_comb begin
    state_next      = state;
    wptr_next       = wptr;
    first_next      = first;
    was_busy_next   = was_busy;
    bad_index_next  = bad_index;
    free_found_next = free_found;
    free_index_next = free_index;
    wr_en           = 1'b0;
    wr_data         = rd_data;
    req.ready       = 1'b0;
    rsp.valid       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          wptr_next  = AW'(count_m1[INDEX_W-1:BIT_W]);
          first_next = 1'b1;
          state_next = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        // Read the item's bit, apply the command, leave bad indices alone.
        bad_index_next  = idx_bad;
        was_busy_next   = idx_bad ? 1'b0 : rd_data[idx_bit];
        free_found_next = 1'b0;
        free_index_next = '0;
        case (cmd_q)
          CMD_BUSY: wr_data[idx_bit] = 1'b1;
          CMD_FREE: wr_data[idx_bit] = 1'b0;
          default:  wr_data = rd_data;
        endcase
        wr_en      = !idx_bad;
        state_next = (count_q == '0) ? ST_DONE : ST_SCAN;
      end

      ST_SCAN: begin
        // Walk down one word per cycle; stop at the first free bit.
        first_next = 1'b0;
        if (scan.any) begin
          free_found_next = 1'b1;
          free_index_next = INDEX_W'({wptr, scan.pos});
          state_next      = ST_DONE;
        end else if (wptr == '0) begin
          state_next = ST_DONE;
        end else begin
          wptr_next = wptr - AW'(1);
        end
      end

      ST_DONE: begin
        rsp.valid = 1'b1;
        if (rsp.ready) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  assign rsp.was_busy   = was_busy;
  assign rsp.bad_index  = bad_index;
  assign rsp.free_found = free_found;
  assign rsp.free_index = free_index;

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("request taken while a result is pending");

  a_bad_not_busy: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.bad_index) |-> !rsp.was_busy)
    else $error("bad index reported as busy");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.free_found) |-> (rsp.free_index == '0))
    else $error("free index nonzero with nothing found");

  a_found_below_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.free_found) |-> ({1'b0, rsp.free_index} < count_q))
    else $error("free index at or above count");

  a_result_from_search: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> ($past(state) == ST_SCAN || $past(state) == ST_UPDATE))
    else $error("result raised without a search");
`endif

endmodule

// File: bench/bitmap_resource_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_resource_allocator_tb: self-checking bench for the bitmap allocator
// Drives query / mark busy / mark free items, mirrors the busy bitmap and the
// resource count, and checks every response against the mirrored outcome.
// ----------------------------------------------------------------------------
// Layout of the bench:
//   - stimulus (initial): resets the block, runs a short directed sequence
//     and then a series of random phases, each at its own resource count.
//     Items go into a pending queue; the count is written only once the
//     block has drained.
//   - request driver (negedge): pops pending items and holds each one on the
//     request channel until it is taken, with a random gap before the next.
//   - response sink (negedge): drops ready for a random number of cycles
//     after each item, and for a long stretch when the hold-off counter runs.
//   - monitor (posedge): tracks count writes, predicts each accepted request
//     and compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module bitmap_resource_allocator_tb;
  import bra_pkg::*;

  // The bitmap spans the smaller of the block's size and the index range
  localparam int NUM_RES     = (NUM_RESOURCES_DEF < INDEX_SPAN) ? NUM_RESOURCES_DEF
                                                                 : INDEX_SPAN;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;  // unused code, acts as a query
  localparam int MAX_GAP     = 16;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_PAUSE = 20;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 40;
  localparam int NUM_PHASES  = 10;
  localparam int CHUNK_ITEMS = 30;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] idx;
  } alloc_req_t;

  typedef struct packed {
    logic               was_busy;
    logic               bad_index;
    logic               free_found;
    logic [INDEX_W-1:0] free_index;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bra_cfg_if cfg_ch ();
  bra_req_if req_ch ();
  bra_rsp_if rsp_ch ();

  bitmap_resource_allocator i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // Shared bench state
  alloc_req_t         pending_req_q [$];
  alloc_rsp_t         expected_rsp_q [$];
  logic [NUM_RES-1:0] busy_map;
  logic [COUNT_W-1:0] count_mirror;
  logic               req_fire_q;
  logic               rsp_fire_q;
  logic               req_offer;
  logic               send_calm;
  logic               recv_calm;
  logic               hold_kick;
  int                 hold_left;
  int                 send_gap;
  int                 recv_gap;
  int                 cycle_count;
  int                 mismatch_count = 0;

  // --------------------------------------------------------------------------
  // Mirror of the allocator: apply one request to the bitmap and work out the
  // response. Out-of-range indexes leave the bitmap alone; the free search
  // only looks below the effective count, highest index first.
  // --------------------------------------------------------------------------
  function automatic alloc_rsp_t predict_alloc(logic [CMD_W-1:0] cmd,
                                               logic [INDEX_W-1:0] idx);
    alloc_rsp_t r;
    int         lim;
    r   = '0;
    lim = (int'(count_mirror) > NUM_RES) ? NUM_RES : int'(count_mirror);
    if (int'(idx) >= lim) begin
      r.bad_index = 1'b1;
    end else begin
      r.was_busy = busy_map[idx];
      if (cmd == CMD_BUSY) begin
        busy_map[idx] = 1'b1;
      end else if (cmd == CMD_FREE) begin
        busy_map[idx] = 1'b0;
      end
    end
    for (int k = lim - 1; k >= 0; k--) begin
      if (!busy_map[k]) begin
        r.free_found = 1'b1;
        r.free_index = INDEX_W'(k);
        break;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    if (mismatch_count < MAX_REPORTS) begin
      $display("mismatch on %s at cycle %0d: expected %0h, got %0h",
               field, cycle_count, want, got);
    end
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Request driver: hold the current item until it is taken, then wait the
  // drawn gap and present the next pending one.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : request_driver
    alloc_req_t cur;
    if (rst) begin
      req_ch.valid   <= 1'b0;
      req_ch.cmd     <= '0;
      req_ch.rsrc_id <= '0;
      req_offer       = 1'b0;
      send_gap        = 0;
    end else begin
      if (req_fire_q) begin
        req_offer = 1'b0;
      end
      if (!req_offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_req_q.size() > 0) begin
          cur = pending_req_q.pop_front();
          req_ch.cmd     <= cur.cmd;
          req_ch.rsrc_id <= cur.idx;
          req_offer = 1'b1;
          send_gap  = send_calm ? 0 : $urandom_range(0, MAX_GAP);
        end
      end
      req_ch.valid <= req_offer;
    end
  end

  // --------------------------------------------------------------------------
  // Response sink: after each item taken, stall for a drawn number of cycles;
  // the long hold-off overrides everything while it runs.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : response_sink
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_gap      = 0;
    end else begin
      if (rsp_fire_q) begin
        recv_gap = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted in cycles once kicked by the stimulus
  always @(posedge clk) begin : hold_counter
    if (rst) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample all handshakes at the rising edge. Count writes update
  // the mirror, accepted requests push a prediction, accepted responses are
  // checked field by field against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    alloc_rsp_t want;
    if (rst) begin
      busy_map     = '0;
      count_mirror = COUNT_RESET;
      cycle_count  = 0;
      req_fire_q  <= 1'b0;
      rsp_fire_q  <= 1'b0;
    end else begin
      cycle_count++;
      req_fire_q <= req_ch.valid && req_ch.ready;
      rsp_fire_q <= rsp_ch.valid && rsp_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        count_mirror = cfg_ch.data;
      end
      if (req_ch.valid && req_ch.ready) begin
        expected_rsp_q.push_back(predict_alloc(req_ch.cmd, req_ch.rsrc_id));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected response", 32'd0, 32'd1);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_ch.was_busy !== want.was_busy)
            report_mismatch("was_busy", 32'(want.was_busy), 32'(rsp_ch.was_busy));
          if (rsp_ch.bad_index !== want.bad_index)
            report_mismatch("bad_index", 32'(want.bad_index), 32'(rsp_ch.bad_index));
          if (rsp_ch.free_found !== want.free_found)
            report_mismatch("free_found", 32'(want.free_found), 32'(rsp_ch.free_found));
          if (rsp_ch.free_index !== want.free_index)
            report_mismatch("free_index", 32'(want.free_index), 32'(rsp_ch.free_index));
        end
      end
    end
  end

  // Hang guard: a stuck handshake ends the run here
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_req(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx);
    pending_req_q.push_back({cmd, idx});
  endtask

  // Block until nothing is queued, offered or outstanding
  task automatic wait_drained();
    while (pending_req_q.size() > 0 || req_offer || expected_rsp_q.size() > 0)
      @(negedge clk);
  endtask

  // Write the resource count once the block is idle
  task automatic write_resource_count(logic [COUNT_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [CMD_W-1:0] draw_cmd(int busy_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < busy_pct) return CMD_BUSY;
    if (r < busy_pct + 30) return CMD_FREE;
    if (r < 95) return CMD_QUERY;
    return CMD_SPARE;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int                 phase_counts [NUM_PHASES];
    int                 cnt;
    int                 budget;
    int                 busy_pct;
    int                 chunk;
    int                 n;
    int                 top;
    int                 run;
    logic               held;
    logic [CMD_W-1:0]   run_cmd;
    logic [INDEX_W-1:0] idx;

    phase_counts = '{256, 1, 32, 33, 255, 64, -1, 0, 256, 160};

    // Known values on the configuration channel and bench controls
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    hold_kick        = 1'b0;
    send_calm        = 1'b1;
    recv_calm        = 1'b1;
    held             = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset count of 256: empty map, top index toggled,
    // repeated marks, the spare command code
    queue_req(CMD_QUERY, 8'd0);
    queue_req(CMD_BUSY,  8'd255);
    queue_req(CMD_BUSY,  8'd255);
    queue_req(CMD_SPARE, 8'd255);
    queue_req(CMD_FREE,  8'd255);
    queue_req(CMD_FREE,  8'd255);
    queue_req(CMD_BUSY,  8'd0);
    queue_req(CMD_QUERY, 8'd128);

    // Three resources, all marked busy: no free resource left; indexes at
    // and far above the count are rejected
    write_resource_count(9'd3);
    queue_req(CMD_BUSY,  8'd2);
    queue_req(CMD_BUSY,  8'd1);
    queue_req(CMD_BUSY,  8'd0);
    queue_req(CMD_QUERY, 8'd3);
    queue_req(CMD_BUSY,  8'd255);

    // Two resources in a partial word whose upper bits are free: those bits
    // must not be reported
    write_resource_count(9'd2);
    queue_req(CMD_QUERY, 8'd1);

    // No resources managed at all
    write_resource_count(9'd0);
    queue_req(CMD_FREE,  8'd0);
    queue_req(CMD_QUERY, 8'd255);

    // Random phases, each at its own count
    for (int p = 0; p < NUM_PHASES; p++) begin
      cnt = (phase_counts[p] < 0) ? int'($urandom_range(2, 254)) : phase_counts[p];
      write_resource_count(COUNT_W'(cnt));
      budget   = (cnt == 0) ? 40 : 146;
      busy_pct = $urandom_range(25, 65);
      while (budget > 0) begin
        send_calm = ($urandom_range(0, 3) == 0);
        recv_calm = ($urandom_range(0, 3) == 0);

        // Once: stall the receiver for a long stretch while items keep coming
        if (p == 2 && !held) begin
          hold_kick <= 1'b1;
          @(negedge clk);
          hold_kick <= 1'b0;
          held = 1'b1;
        end

        chunk = (budget < CHUNK_ITEMS) ? budget : CHUNK_ITEMS;
        n = 0;
        while (n < chunk) begin
          if (cnt > 0 && $urandom_range(0, 99) < 10) begin
            // Consecutive marks walking down from near the top, so the free
            // search has to go deep into the bitmap
            run_cmd = ($urandom_range(0, 2) == 0) ? CMD_FREE : CMD_BUSY;
            top     = cnt - 1 - int'($urandom_range(0, cnt / 8));
            run     = $urandom_range(4, 48);
            for (int k = 0; k < run && top - k >= 0; k++) begin
              queue_req(run_cmd, INDEX_W'(top - k));
              n++;
            end
          end else begin
            if (cnt > 0 && $urandom_range(0, 99) < 85)
              idx = INDEX_W'($urandom_range(0, cnt - 1));
            else
              idx = INDEX_W'($urandom_range(0, 255));
            queue_req(draw_cmd(busy_pct), idx);
            n++;
          end
        end
        budget -= n;

        // Let the driver empty the queue before the next chunk
        while (pending_req_q.size() > 0) @(negedge clk);
        // Now and then pause the sender until every response is back
        if ($urandom_range(0, 4) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_PAUSE) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
